/* hw/rtl/cdt_pkg.sv */
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared constants, command and operation codes, preset and alarm tables.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int NUM_PRESETS       = 11;
  localparam int NUM_ALARM_LENGTHS = 4;
  localparam int MS_PER_SECOND     = 1000;

  localparam int W_SEC    = 15;
  localparam int W_MS     = 10;
  localparam int W_PRESET = 4;
  localparam int W_ALARM  = 2;
  localparam int W_CMD    = 4;
  localparam int W_STEP   = 12;
  localparam int W_CFG    = 15;
  localparam int W_CFGIDX = 2;

  typedef enum logic [W_CMD-1:0] {
    CMD_TICK       = 4'd0,
    CMD_STARTPAUSE = 4'd1,
    CMD_RESET      = 4'd2,
    CMD_SELECT     = 4'd3,
    CMD_PREV       = 4'd4,
    CMD_NEXT       = 4'd5,
    CMD_ADD        = 4'd6,
    CMD_REMOVE     = 4'd7,
    CMD_CYCLEALARM = 4'd8,
    CMD_SILENCE    = 4'd9
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TICK,
    OP_STARTPAUSE,
    OP_RESET,
    OP_SELECT,
    OP_PREV,
    OP_NEXT,
    OP_ADD,
    OP_REMOVE,
    OP_CYCLEALARM,
    OP_SILENCE
  } op_t;

  typedef enum logic [W_CFGIDX-1:0] {
    CFG_BEEP_INTERVAL = 2'd0,
    CFG_MAX_DURATION  = 2'd1,
    CFG_MIN_DURATION  = 2'd2,
    CFG_ADJUST_STEP   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                 op;
    logic [W_PRESET-1:0] choice;
    logic                choice_ok;
  } op_item_t;

  typedef struct packed {
    logic [W_MS-1:0]   beep_interval_ms;
    logic [W_SEC-1:0]  max_duration_s;
    logic [W_SEC-1:0]  min_duration_s;
    logic [W_STEP-1:0] adjust_step_s;
  } cfg_t;

  typedef struct packed {
    logic [W_SEC-1:0]    remaining_s;
    logic [W_SEC-1:0]    total_s;
    logic                is_running;
    logic                is_finished;
    logic                alarm_on;
    logic                blink_phase;
    logic                beep_pulse;
    logic [W_PRESET-1:0] preset_selected;
    logic [W_ALARM-1:0]  alarm_choice;
  } result_t;

  localparam logic [W_MS-1:0]     BEEP_INTERVAL_RST = 10'd700;
  localparam logic [W_SEC-1:0]    MAX_DURATION_RST  = 15'd21600;
  localparam logic [W_SEC-1:0]    MIN_DURATION_RST  = 15'd60;
  localparam logic [W_STEP-1:0]   ADJUST_STEP_RST   = 12'd60;
  localparam logic [W_PRESET-1:0] PRESET_RST        = 4'd2;
  localparam logic [W_SEC-1:0]    TOTAL_RST         = 15'd300;
  localparam logic [W_ALARM-1:0]  ALARM_RST         = 2'd1;

  function automatic logic [W_SEC-1:0] preset_value(input logic [W_PRESET-1:0] idx);
    logic [W_SEC-1:0] v;
    case (idx)
      4'd0:    v = 15'd60;
      4'd1:    v = 15'd180;
      4'd2:    v = 15'd300;
      4'd3:    v = 15'd600;
      4'd4:    v = 15'd900;
      4'd5:    v = 15'd1500;
      4'd6:    v = 15'd1800;
      4'd7:    v = 15'd2700;
      4'd8:    v = 15'd3600;
      4'd9:    v = 15'd7200;
      default: v = 15'd10800;
    endcase
    return v;
  endfunction

  function automatic logic [W_SEC-1:0] alarm_limit_ms(input logic [W_ALARM-1:0] idx);
    logic [W_SEC-1:0] v;
    case (idx)
      2'd0:    v = 15'd3000;
      2'd1:    v = 15'd5000;
      2'd2:    v = 15'd10000;
      default: v = 15'd30000;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/cdt_in_if.sv */
// ----------------------------------------------------------------------------
// Countdown timer command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface cdt_in_if import cdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [W_CMD-1:0]    command;
  logic [W_PRESET-1:0] preset_choice;

  modport source (output valid, output command, output preset_choice, input ready);
  modport sink   (input valid, input command, input preset_choice, output ready);
endinterface

/* hw/rtl/cdt_out_if.sv */
// ----------------------------------------------------------------------------
// Countdown timer result channel
// Valid/ready channel that carries one timer status beat.
// ----------------------------------------------------------------------------
interface cdt_out_if import cdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [W_SEC-1:0]    remaining_s;
  logic [W_SEC-1:0]    total_s;
  logic                is_running;
  logic                is_finished;
  logic                alarm_on;
  logic                blink_phase;
  logic                beep_pulse;
  logic [W_PRESET-1:0] preset_selected;
  logic [W_ALARM-1:0]  alarm_choice;

  modport source (output valid, output remaining_s, output total_s, output is_running,
                  output is_finished, output alarm_on, output blink_phase,
                  output beep_pulse, output preset_selected, output alarm_choice,
                  input ready);
  modport sink   (input valid, input remaining_s, input total_s, input is_running,
                  input is_finished, input alarm_on, input blink_phase,
                  input beep_pulse, input preset_selected, input alarm_choice,
                  output ready);
endinterface

/* hw/rtl/cdt_front.sv */
// ----------------------------------------------------------------------------
// Countdown timer front end
// Accepts command beats and decodes them into timer operations.
// ----------------------------------------------------------------------------
module cdt_front import cdt_pkg::*; (
  cdt_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output op_item_t push_item
);

  op_t op;

  always_comb begin
    case (in_ch.command)
      CMD_TICK:       op = OP_TICK;
      CMD_STARTPAUSE: op = OP_STARTPAUSE;
      CMD_RESET:      op = OP_RESET;
      CMD_SELECT:     op = OP_SELECT;
      CMD_PREV:       op = OP_PREV;
      CMD_NEXT:       op = OP_NEXT;
      CMD_ADD:        op = OP_ADD;
      CMD_REMOVE:     op = OP_REMOVE;
      CMD_CYCLEALARM: op = OP_CYCLEALARM;
      CMD_SILENCE:    op = OP_SILENCE;
      default:        op = OP_NOP;
    endcase
  end

  assign in_ch.ready         = !q_full;
  assign push                = in_ch.valid && !q_full;
  assign push_item.op        = op;
  assign push_item.choice    = in_ch.preset_choice;
  assign push_item.choice_ok = ({1'b0, in_ch.preset_choice} < 5'(NUM_PRESETS));

endmodule

/* hw/rtl/cdt_queue.sv */
// ----------------------------------------------------------------------------
// Countdown timer operation queue
// Two-entry queue that decouples the decoder from the timer engine.
// ----------------------------------------------------------------------------
module cdt_queue import cdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  op_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output op_item_t pop_item
);

  op_item_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/cdt_back.sv */
// ----------------------------------------------------------------------------
// Countdown timer engine
// Executes timer operations, runs the alarm and registers each status beat.
// ----------------------------------------------------------------------------
module cdt_back import cdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  op_item_t q_item,
  output logic     pop,
  cdt_out_if.source out_ch
);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [W_PRESET-1:0] preset_r, preset_nxt;
  logic [W_SEC-1:0]    total_r, total_nxt;
  logic [W_SEC-1:0]    remain_r, remain_nxt;
  logic [W_MS-1:0]     phase_r, phase_nxt;
  logic [W_ALARM-1:0]  alarm_idx_r, alarm_idx_nxt;
  logic                alarm_r, alarm_nxt;
  logic [W_SEC-1:0]    alarm_ms_r, alarm_ms_nxt;
  logic [W_MS-1:0]     beep_ms_r, beep_ms_nxt;
  logic                blink_r, blink_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;

  logic                pulse, started, do_load;
  logic [W_PRESET-1:0] load_idx;
  logic [W_MS-1:0]     phase_inc;
  logic [W_SEC-1:0]    alarm_ms_inc;
  logic [W_MS-1:0]     beep_ms_inc;
  logic signed [16:0]  adj_sum;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    run_nxt       = run_r;
    done_nxt      = done_r;
    preset_nxt    = preset_r;
    total_nxt     = total_r;
    remain_nxt    = remain_r;
    phase_nxt     = phase_r;
    alarm_idx_nxt = alarm_idx_r;
    alarm_nxt     = alarm_r;
    alarm_ms_nxt  = alarm_ms_r;
    beep_ms_nxt   = beep_ms_r;
    blink_nxt     = blink_r;
    pulse         = 1'b0;
    started       = 1'b0;
    do_load       = 1'b0;
    load_idx      = preset_r;
    phase_inc     = phase_r + 10'd1;
    alarm_ms_inc  = alarm_ms_r + 15'd1;
    beep_ms_inc   = beep_ms_r + 10'd1;
    adj_sum       = '0;

    if (pop) begin
      if (q_item.op == OP_TICK) begin
        if (run_r && !done_r) begin
          if (phase_inc >= 10'(MS_PER_SECOND)) begin
            phase_nxt = '0;
            if (remain_r != '0) begin
              remain_nxt = remain_r - 15'd1;
              if (remain_r == 15'd1) begin
                done_nxt     = 1'b1;
                run_nxt      = 1'b0;
                alarm_nxt    = 1'b1;
                alarm_ms_nxt = '0;
                beep_ms_nxt  = '0;
                blink_nxt    = 1'b1;
                pulse        = 1'b1;
                started      = 1'b1;
              end
            end
          end else begin
            phase_nxt = phase_inc;
          end
        end
        if (alarm_r && !started) begin
          alarm_ms_nxt = alarm_ms_inc;
          if (alarm_ms_inc >= alarm_limit_ms(alarm_idx_r)) begin
            alarm_nxt = 1'b0;
            blink_nxt = 1'b0;
          end else if (beep_ms_inc >= cfg.beep_interval_ms) begin
            beep_ms_nxt = '0;
            blink_nxt   = !blink_r;
            pulse       = 1'b1;
          end else begin
            beep_ms_nxt = beep_ms_inc;
          end
        end
      end else if (q_item.op != OP_NOP && alarm_r) begin
        alarm_nxt = 1'b0;
        blink_nxt = 1'b0;
      end else begin
        case (q_item.op)
          OP_STARTPAUSE: begin
            alarm_nxt = 1'b0;
            if (done_r) begin
              done_nxt   = 1'b0;
              remain_nxt = total_r;
              run_nxt    = 1'b1;
              phase_nxt  = '0;
            end else begin
              run_nxt = !run_r;
              if (!run_r) begin
                phase_nxt = '0;
              end
            end
          end
          OP_RESET: begin
            alarm_nxt  = 1'b0;
            run_nxt    = 1'b0;
            done_nxt   = 1'b0;
            total_nxt  = preset_value(preset_r);
            remain_nxt = preset_value(preset_r);
          end
          OP_SELECT: begin
            do_load  = !run_r && q_item.choice_ok;
            load_idx = q_item.choice;
          end
          OP_PREV: begin
            do_load  = !run_r;
            load_idx = (preset_r != '0) ? preset_r - 4'd1 : 4'(NUM_PRESETS - 1);
          end
          OP_NEXT: begin
            do_load  = !run_r;
            load_idx = (({1'b0, preset_r} + 5'd1) < 5'(NUM_PRESETS)) ?
                       preset_r + 4'd1 : '0;
          end
          OP_ADD, OP_REMOVE: begin
            if (!run_r) begin
              if (q_item.op == OP_ADD) begin
                adj_sum = $signed({2'b00, total_r}) + $signed({5'b0, cfg.adjust_step_s});
              end else begin
                adj_sum = $signed({2'b00, total_r}) - $signed({5'b0, cfg.adjust_step_s});
              end
              if (adj_sum < $signed({2'b00, cfg.min_duration_s})) begin
                adj_sum = $signed({2'b00, cfg.min_duration_s});
              end
              if (adj_sum > $signed({2'b00, cfg.max_duration_s})) begin
                adj_sum = $signed({2'b00, cfg.max_duration_s});
              end
              total_nxt  = adj_sum[W_SEC-1:0];
              remain_nxt = adj_sum[W_SEC-1:0];
              done_nxt   = 1'b0;
              alarm_nxt  = 1'b0;
            end
          end
          OP_CYCLEALARM: begin
            alarm_idx_nxt = (alarm_idx_r == 2'(NUM_ALARM_LENGTHS - 1)) ?
                            '0 : alarm_idx_r + 2'd1;
          end
          default: begin
          end
        endcase
        if (do_load) begin
          preset_nxt = load_idx;
          total_nxt  = preset_value(load_idx);
          remain_nxt = preset_value(load_idx);
          done_nxt   = 1'b0;
          alarm_nxt  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    res_nxt = res_r;
    if (pop) begin
      res_nxt.remaining_s     = remain_nxt;
      res_nxt.total_s         = total_nxt;
      res_nxt.is_running      = run_nxt;
      res_nxt.is_finished     = done_nxt;
      res_nxt.alarm_on        = alarm_nxt;
      res_nxt.blink_phase     = blink_nxt;
      res_nxt.beep_pulse      = pulse;
      res_nxt.preset_selected = preset_nxt;
      res_nxt.alarm_choice    = alarm_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      done_r      <= 1'b0;
      preset_r    <= PRESET_RST;
      total_r     <= TOTAL_RST;
      remain_r    <= TOTAL_RST;
      phase_r     <= '0;
      alarm_idx_r <= ALARM_RST;
      alarm_r     <= 1'b0;
      alarm_ms_r  <= '0;
      beep_ms_r   <= '0;
      blink_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      done_r      <= done_nxt;
      preset_r    <= preset_nxt;
      total_r     <= total_nxt;
      remain_r    <= remain_nxt;
      phase_r     <= phase_nxt;
      alarm_idx_r <= alarm_idx_nxt;
      alarm_r     <= alarm_nxt;
      alarm_ms_r  <= alarm_ms_nxt;
      beep_ms_r   <= beep_ms_nxt;
      blink_r     <= blink_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.remaining_s     = res_r.remaining_s;
  assign out_ch.total_s         = res_r.total_s;
  assign out_ch.is_running      = res_r.is_running;
  assign out_ch.is_finished     = res_r.is_finished;
  assign out_ch.alarm_on        = res_r.alarm_on;
  assign out_ch.blink_phase     = res_r.blink_phase;
  assign out_ch.beep_pulse      = res_r.beep_pulse;
  assign out_ch.preset_selected = res_r.preset_selected;
  assign out_ch.alarm_choice    = res_r.alarm_choice;

endmodule

/* hw/rtl/countdown_timer_with_alarm_top.sv */
// ----------------------------------------------------------------------------
// Countdown timer with alarm
// The block takes one command beat per clock cycle while its queue is not full
// and returns exactly one status beat for each, in order. A beat passes the
// command decoder, a two-entry operation queue and the timer engine, whose
// status register drives the result channel; both the queue and that register
// hold it in turn. The engine retires one operation per cycle unless the queue
// is empty or the result channel stalls. The user must write configuration
// through the cfg_ port only while no beat is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module countdown_timer_with_alarm_top import cdt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  cdt_in_if.sink              in_ch,
  cdt_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [W_CFGIDX-1:0] cfg_index,
  input  logic [W_CFG-1:0]    cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_full, push, pop, q_valid;
  op_item_t push_item, pop_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BEEP_INTERVAL: cfg_nxt.beep_interval_ms = cfg_wdata[W_MS-1:0];
        CFG_MAX_DURATION:  cfg_nxt.max_duration_s   = cfg_wdata[W_SEC-1:0];
        CFG_MIN_DURATION:  cfg_nxt.min_duration_s   = cfg_wdata[W_SEC-1:0];
        CFG_ADJUST_STEP:   cfg_nxt.adjust_step_s    = cfg_wdata[W_STEP-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beep_interval_ms <= BEEP_INTERVAL_RST;
      cfg_r.max_duration_s   <= MAX_DURATION_RST;
      cfg_r.min_duration_s   <= MIN_DURATION_RST;
      cfg_r.adjust_step_s    <= ADJUST_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cdt_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cdt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  cdt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* test/cdt_status_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer status checker
// Watches the command, status and configuration ports of the countdown timer.
// Every accepted command beat is run through a cycle-free model of the timer,
// alarm and beeper, and the predicted status is queued. Every accepted status
// beat is compared field by field with the oldest prediction. The failure
// count is handed to the testbench top.
// ----------------------------------------------------------------------------
module cdt_status_checker import cdt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  cdt_in_if                   in_ch,
  cdt_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [W_CFGIDX-1:0] cfg_index,
  input  logic [W_CFG-1:0]    cfg_wdata,
  input  logic                end_of_test,
  output int                  fail_count
);

  int unsigned preset_secs [NUM_PRESETS] = '{60, 180, 300, 600, 900, 1500, 1800, 2700,
                                             3600, 7200, 10800};
  int unsigned alarm_len_s [NUM_ALARM_LENGTHS] = '{3, 5, 10, 30};

  logic [W_MS-1:0]     beep_ivl;
  logic [W_SEC-1:0]    longest_s;
  logic [W_SEC-1:0]    shortest_s;
  logic [W_STEP-1:0]   step_s;

  logic                running;
  logic                finished;
  logic                alarm;
  logic                blink;
  logic [W_PRESET-1:0] cur_preset;
  logic [W_SEC-1:0]    total;
  logic [W_SEC-1:0]    remaining;
  logic [W_MS-1:0]     ms_in_second;
  logic [W_ALARM-1:0]  alarm_sel;
  logic [W_SEC-1:0]    alarm_ms;
  logic [W_MS-1:0]     beep_ms;

  result_t pending_status [$];
  bit      end_checked;

  function automatic logic [W_SEC-1:0] preset_len(input logic [W_PRESET-1:0] idx);
    if (idx < NUM_PRESETS) begin
      return W_SEC'(preset_secs[idx]);
    end
    return W_SEC'(10800);
  endfunction

  task automatic pick_preset(input logic [W_PRESET-1:0] idx);
    cur_preset = idx;
    total      = preset_len(idx);
    remaining  = total;
    finished   = 1'b0;
    alarm      = 1'b0;
  endtask

  task automatic adjust_total(input logic up);
    int v;
    v = up ? int'(total) + int'(step_s) : int'(total) - int'(step_s);
    if (v < int'(shortest_s)) v = int'(shortest_s);
    if (v > int'(longest_s)) v = int'(longest_s);
    total     = v[W_SEC-1:0];
    remaining = total;
    finished  = 1'b0;
    alarm     = 1'b0;
  endtask

  task automatic predict_status(input logic [W_CMD-1:0] cmd,
                                input logic [W_PRESET-1:0] choice,
                                output result_t st);
    logic pulse;
    logic alarm_started;
    pulse         = 1'b0;
    alarm_started = 1'b0;
    if (cmd == CMD_TICK) begin
      if (running && !finished) begin
        ms_in_second = ms_in_second + 1'b1;
        if (ms_in_second >= MS_PER_SECOND) begin
          ms_in_second = '0;
          if (remaining != '0) begin
            remaining = remaining - 1'b1;
            if (remaining == '0) begin
              finished      = 1'b1;
              running       = 1'b0;
              alarm         = 1'b1;
              alarm_ms      = '0;
              beep_ms       = '0;
              blink         = 1'b1;
              pulse         = 1'b1;
              alarm_started = 1'b1;
            end
          end
        end
      end
      if (alarm && !alarm_started) begin
        alarm_ms = alarm_ms + 1'b1;
        if (alarm_ms >= alarm_len_s[alarm_sel] * MS_PER_SECOND) begin
          alarm = 1'b0;
          blink = 1'b0;
        end else begin
          beep_ms = beep_ms + 1'b1;
          if (beep_ms >= beep_ivl) begin
            beep_ms = '0;
            blink   = !blink;
            pulse   = 1'b1;
          end
        end
      end
    end else if (cmd <= CMD_SILENCE && alarm) begin
      alarm = 1'b0;
      blink = 1'b0;
    end else begin
      case (cmd)
        CMD_STARTPAUSE: begin
          alarm = 1'b0;
          if (finished) begin
            finished     = 1'b0;
            remaining    = total;
            running      = 1'b1;
            ms_in_second = '0;
          end else begin
            running = !running;
            if (running) ms_in_second = '0;
          end
        end
        CMD_RESET: begin
          alarm     = 1'b0;
          running   = 1'b0;
          finished  = 1'b0;
          total     = preset_len(cur_preset);
          remaining = total;
        end
        CMD_SELECT: if (!running && choice < NUM_PRESETS) pick_preset(choice);
        CMD_PREV: begin
          if (!running) begin
            pick_preset(cur_preset > 0 ? cur_preset - 1'b1 : W_PRESET'(NUM_PRESETS - 1));
          end
        end
        CMD_NEXT: begin
          if (!running) pick_preset(cur_preset + 1 < NUM_PRESETS ? cur_preset + 1'b1 : '0);
        end
        CMD_ADD: if (!running) adjust_total(1'b1);
        CMD_REMOVE: if (!running) adjust_total(1'b0);
        CMD_CYCLEALARM: alarm_sel = W_ALARM'((alarm_sel + 1) % NUM_ALARM_LENGTHS);
        default: ;
      endcase
    end
    st.remaining_s     = remaining;
    st.total_s         = total;
    st.is_running      = running;
    st.is_finished     = finished;
    st.alarm_on        = alarm;
    st.blink_phase     = blink;
    st.beep_pulse      = pulse;
    st.preset_selected = cur_preset;
    st.alarm_choice    = alarm_sel;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    if (!rst_n) begin
      beep_ivl     = BEEP_INTERVAL_RST;
      longest_s    = MAX_DURATION_RST;
      shortest_s   = MIN_DURATION_RST;
      step_s       = ADJUST_STEP_RST;
      running      = 1'b0;
      finished     = 1'b0;
      alarm        = 1'b0;
      blink        = 1'b0;
      cur_preset   = PRESET_RST;
      total        = TOTAL_RST;
      remaining    = TOTAL_RST;
      ms_in_second = '0;
      alarm_sel    = ALARM_RST;
      alarm_ms     = '0;
      beep_ms      = '0;
      fail_count   = 0;
      end_checked  = 1'b0;
      pending_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEEP_INTERVAL: beep_ivl   = cfg_wdata[W_MS-1:0];
          CFG_MAX_DURATION:  longest_s  = cfg_wdata[W_SEC-1:0];
          CFG_MIN_DURATION:  shortest_s = cfg_wdata[W_SEC-1:0];
          CFG_ADJUST_STEP:   step_s     = cfg_wdata[W_STEP-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          $error("status beat arrived with no command pending");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("remaining_s", want.remaining_s, out_ch.remaining_s);
          check_field("total_s", want.total_s, out_ch.total_s);
          check_field("is_running", want.is_running, out_ch.is_running);
          check_field("is_finished", want.is_finished, out_ch.is_finished);
          check_field("alarm_on", want.alarm_on, out_ch.alarm_on);
          check_field("blink_phase", want.blink_phase, out_ch.blink_phase);
          check_field("beep_pulse", want.beep_pulse, out_ch.beep_pulse);
          check_field("preset_selected", want.preset_selected, out_ch.preset_selected);
          check_field("alarm_choice", want.alarm_choice, out_ch.alarm_choice);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_status(in_ch.command, in_ch.preset_choice, got);
        pending_status.push_back(got);
      end
      if (end_of_test && !end_checked) begin
        end_checked = 1'b1;
        if (pending_status.size() != 0) begin
          $error("%0d status beats never arrived", pending_status.size());
          fail_count++;
        end
      end
    end
  end

endmodule

/* test/tb_countdown_timer_with_alarm_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer with alarm testbench
// Drives command beats and configuration writes into the timer while the
// result channel is stalled at random. A short directed run covers preset
// wrap, ignored commands and unknown codes; random phases under several
// register settings then mix loose commands with short bursts of ticks.
// A separate checker predicts and compares every status beat.
// ----------------------------------------------------------------------------
module tb_countdown_timer_with_alarm_top;
  import cdt_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_STEPS = 30;
  localparam int NUM_PHASES   = 6;

  localparam logic [W_CMD-1:0] CMD_UNKNOWN_LO = 4'd10;
  localparam logic [W_CMD-1:0] CMD_UNKNOWN_HI = 4'd15;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [W_CFGIDX-1:0] cfg_index;
  logic [W_CFG-1:0]    cfg_wdata;
  logic                end_of_test;
  int                  fail_count;

  int cycle_count = 0;
  int beats_sent  = 0;
  int beats_back  = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;
  bit stall_on    = 1'b1;

  cdt_in_if  in_ch ();
  cdt_out_if out_ch ();

  countdown_timer_with_alarm_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cdt_status_checker u_status_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .end_of_test (end_of_test),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [W_PRESET-1:0] any_choice();
    return W_PRESET'($urandom_range(0, 15));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_ch.valid && in_ch.ready) beats_sent <= beats_sent + 1;
    if (out_ch.valid && out_ch.ready) beats_back <= beats_back + 1;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 15) begin
      out_ch.ready <= 1'b0;
      stall_left   <= idle_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [W_CMD-1:0] code, input logic [W_PRESET-1:0] choice);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 20) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= code;
    in_ch.preset_choice <= choice;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_cmd(CMD_TICK, any_choice());
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 5) == 0) begin
      send_cmd(W_CMD'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)), any_choice());
    end else begin
      send_cmd(W_CMD'($urandom_range(CMD_TICK, CMD_SILENCE)), any_choice());
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_back != beats_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input logic [W_MS-1:0] beep, input logic [W_SEC-1:0] longest,
                             input logic [W_SEC-1:0] shortest, input logic [W_STEP-1:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BEEP_INTERVAL;
    cfg_wdata <= W_CFG'(beep);
    @(posedge clk);
    cfg_index <= CFG_MAX_DURATION;
    cfg_wdata <= W_CFG'(longest);
    @(posedge clk);
    cfg_index <= CFG_MIN_DURATION;
    cfg_wdata <= W_CFG'(shortest);
    @(posedge clk);
    cfg_index <= CFG_ADJUST_STEP;
    cfg_wdata <= W_CFG'(step);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pick;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_TICK;
    in_ch.preset_choice <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_BEEP_INTERVAL;
    cfg_wdata           <= '0;
    end_of_test         <= 1'b0;
    rst_n               <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(CMD_SILENCE, any_choice());
    send_cmd(CMD_CYCLEALARM, any_choice());
    send_cmd(CMD_SELECT, 4'd10);
    send_cmd(CMD_NEXT, any_choice());
    send_cmd(CMD_PREV, any_choice());
    send_cmd(CMD_SELECT, 4'd11);
    send_cmd(CMD_SELECT, 4'd15);
    send_cmd(CMD_SELECT, 4'd0);
    send_cmd(CMD_REMOVE, any_choice());
    send_cmd(CMD_ADD, any_choice());
    send_cmd(CMD_UNKNOWN_LO, any_choice());
    send_cmd(CMD_UNKNOWN_HI, 4'd15);
    send_cmd(CMD_STARTPAUSE, any_choice());
    send_cmd(CMD_TICK, any_choice());
    send_cmd(CMD_SELECT, 4'd3);
    send_cmd(CMD_PREV, any_choice());
    send_cmd(CMD_NEXT, any_choice());
    send_cmd(CMD_ADD, any_choice());
    send_cmd(CMD_REMOVE, any_choice());
    send_cmd(CMD_STARTPAUSE, any_choice());
    send_cmd(CMD_TICK, any_choice());
    send_cmd(CMD_STARTPAUSE, any_choice());
    send_cmd(CMD_RESET, any_choice());
    send_cmd(CMD_CYCLEALARM, any_choice());

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        1: load_config(10'd1, 15'd60, 15'd1, 12'd3600);
        2: load_config(10'd1023, 15'd32767, 15'd2, 12'd60);
        3: load_config(W_MS'($urandom_range(1, 40)), 15'd32767, 15'd32767, 12'd1);
        4: load_config(W_MS'($urandom_range(1, 1023)), 15'd60, 15'd32767,
                       W_STEP'($urandom_range(1, 3600)));
        5: load_config(W_MS'($urandom_range(2, 30)), W_SEC'($urandom_range(60, 32767)),
                       W_SEC'($urandom_range(1, 3)), W_STEP'($urandom_range(60, 3600)));
        default: load_config(10'd0, W_SEC'($urandom_range(60, 32767)), 15'd0, 12'd59);
      endcase
      repeat (RANDOM_STEPS) begin
        if ($urandom_range(0, 19) == 0) begin
          idle_on  = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) send_noise();
        else send_ticks($urandom_range(1, 8));
      end
    end

    wait_idle();
    end_of_test <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("** countdown_timer_with_alarm_top: PASSED **");
    end else begin
      $display("** countdown_timer_with_alarm_top: FAILED **");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("** countdown_timer_with_alarm_top: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_in_if.sv
hw/rtl/cdt_out_if.sv
hw/rtl/cdt_front.sv
hw/rtl/cdt_queue.sv
hw/rtl/cdt_back.sv
hw/rtl/countdown_timer_with_alarm_top.sv
test/cdt_status_checker.sv
test/tb_countdown_timer_with_alarm_top.sv
